/* sv/mexp_pkg.sv */
// Shared widths for the modular exponentiation block.
// No dependencies; imported by the channel interfaces and all modules.
package mexp_pkg;

   localparam int FIELD_WIDTH   = 63;
   localparam int MODULUS_WIDTH = 32;
   localparam int RESULT_WIDTH  = 32;
   localparam int COUNT_WIDTH   = 6;

endpackage

/* sv/mexp_req_if.sv */
// Request channel: base, exponent and modulus with valid/ready.
// Depends on mexp_pkg for field widths.
interface mexp_req_if import mexp_pkg::*; ();

   logic                     valid;
   logic                     ready;
   logic [FIELD_WIDTH-1:0]   base_value;
   logic [FIELD_WIDTH-1:0]   exponent;
   logic [MODULUS_WIDTH-1:0] modulus;

   modport source (output valid, output base_value, output exponent, output modulus,
                   input ready);
   modport sink   (input valid, input base_value, input exponent, input modulus,
                   output ready);

endinterface

/* sv/mexp_rsp_if.sv */
// Response channel: modular power result with valid/ready.
// Depends on mexp_pkg for the result width.
interface mexp_rsp_if import mexp_pkg::*; ();

   logic                    valid;
   logic                    ready;
   logic [RESULT_WIDTH-1:0] power_result;

   modport source (output valid, output power_result, input ready);
   modport sink   (input valid, input power_result, output ready);

endinterface

/* sv/mexp_mulmod.sv */
// Iterative shift-add modular multiplier, one multiplier bit per cycle, MSB first.
// Depends on mexp_pkg; used by modular_exponentiation for all reductions.
module mexp_mulmod import mexp_pkg::*; #(
   parameter int MOD_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [FIELD_WIDTH-1:0] multiplier,
   input  logic [COUNT_WIDTH-1:0] step_count,
   input  logic [MOD_WIDTH-1:0]   multiplicand,
   input  logic [MOD_WIDTH-1:0]   modulus,
   output logic                   done,
   output logic [MOD_WIDTH-1:0]   product
);

   localparam int SUM_WIDTH = MOD_WIDTH + 2;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [FIELD_WIDTH-1:0] mplr_ff, mplr_in;
   logic [MOD_WIDTH-1:0]   mcand_ff, mcand_in;
   logic [MOD_WIDTH-1:0]   mod_ff, mod_in;
   logic [MOD_WIDTH-1:0]   rem_ff, rem_in;

   logic [SUM_WIDTH-1:0]   sum;
   logic [SUM_WIDTH-1:0]   mod_once;
   logic [SUM_WIDTH-1:0]   mod_twice;
   logic [SUM_WIDTH-1:0]   reduced;

   always_comb begin
      sum       = {1'b0, rem_ff, 1'b0}
                + (mplr_ff[FIELD_WIDTH-1] ? {2'b00, mcand_ff} : {SUM_WIDTH{1'b0}});
      mod_once  = {2'b00, mod_ff};
      mod_twice = {1'b0, mod_ff, 1'b0};
      priority if (sum >= mod_twice) begin
         reduced = sum - mod_twice;
      end else if (sum >= mod_once) begin
         reduced = sum - mod_once;
      end else begin
         reduced = sum;
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      mplr_in  = mplr_ff;
      mcand_in = mcand_ff;
      mod_in   = mod_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = step_count;
         mplr_in  = multiplier;
         mcand_in = multiplicand;
         mod_in   = modulus;
         rem_in   = '0;
      end else if (busy_ff) begin
         rem_in   = reduced[MOD_WIDTH-1:0];
         mplr_in  = {mplr_ff[FIELD_WIDTH-2:0], 1'b0};
         count_in = count_ff - COUNT_WIDTH'(1);
         if (count_ff == COUNT_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      mplr_ff  <= mplr_in;
      mcand_ff <= mcand_in;
      mod_ff   <= mod_in;
      rem_ff   <= rem_in;
   end

   assign done    = done_ff;
   assign product = rem_ff;

endmodule

/* sv/modular_exponentiation.sv */
// Right-to-left square-and-multiply exponentiation over one shared mulmod unit.
// A zero exponent or zero modulus answers in the cycle after the request is taken. One request
// at a time: the next is taken in the cycle after the result is accepted; the serial
// multiplier works one bit per cycle. Synchronous reset returns to idle.
module modular_exponentiation import mexp_pkg::*; #(
   parameter int MOD_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   mexp_req_if.sink   req_chan,
   mexp_rsp_if.source rsp_chan
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_REDUCE = 6'b000010,
      ST_PICK   = 6'b000100,
      ST_MULT   = 6'b001000,
      ST_SQUARE = 6'b010000,
      ST_RESP   = 6'b100000
   } state_type;

   localparam int PAD_WIDTH = FIELD_WIDTH - MOD_WIDTH;

   state_type              state_ff, state_in;
   logic [FIELD_WIDTH-1:0] exp_ff, exp_in;
   logic [MOD_WIDTH-1:0]   mod_ff, mod_in;
   logic [MOD_WIDTH-1:0]   base_ff, base_in;
   logic [MOD_WIDTH-1:0]   acc_ff, acc_in;

   logic                   unit_start;
   logic [FIELD_WIDTH-1:0] unit_mplr;
   logic [COUNT_WIDTH-1:0] unit_count;
   logic [MOD_WIDTH-1:0]   unit_mcand;
   logic [MOD_WIDTH-1:0]   unit_mod;
   logic                   unit_done;
   logic [MOD_WIDTH-1:0]   unit_product;
   logic [MOD_WIDTH-1:0]   req_mod;

   assign req_mod = req_chan.modulus[MOD_WIDTH-1:0];

   mexp_mulmod #(
      .MOD_WIDTH (MOD_WIDTH)
   ) u_mulmod (
      .clock        (clock),
      .reset        (reset),
      .start        (unit_start),
      .multiplier   (unit_mplr),
      .step_count   (unit_count),
      .multiplicand (unit_mcand),
      .modulus      (unit_mod),
      .done         (unit_done),
      .product      (unit_product)
   );

   always_comb begin
      state_in   = state_ff;
      exp_in     = exp_ff;
      mod_in     = mod_ff;
      base_in    = base_ff;
      acc_in     = acc_ff;
      unit_start = 1'b0;
      unit_mplr  = {base_ff, {PAD_WIDTH{1'b0}}};
      unit_count = COUNT_WIDTH'(MOD_WIDTH);
      unit_mcand = base_ff;
      unit_mod   = mod_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               exp_in = req_chan.exponent;
               mod_in = req_mod;
               if (req_chan.exponent == '0) begin
                  acc_in   = MOD_WIDTH'(1);
                  state_in = ST_RESP;
               end else if (req_mod == '0) begin
                  acc_in   = '0;
                  state_in = ST_RESP;
               end else begin
                  acc_in     = MOD_WIDTH'(1);
                  unit_start = 1'b1;
                  unit_mplr  = req_chan.base_value;
                  unit_count = COUNT_WIDTH'(FIELD_WIDTH);
                  unit_mcand = MOD_WIDTH'(1);
                  unit_mod   = req_mod;
                  state_in   = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (unit_done) begin
               base_in  = unit_product;
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            if (exp_ff == '0) begin
               state_in = ST_RESP;
            end else if (exp_ff[0]) begin
               unit_start = 1'b1;
               unit_mplr  = {acc_ff, {PAD_WIDTH{1'b0}}};
               state_in   = ST_MULT;
            end else begin
               unit_start = 1'b1;
               state_in   = ST_SQUARE;
            end
         end
         ST_MULT: begin
            if (unit_done) begin
               acc_in     = unit_product;
               unit_start = 1'b1;
               state_in   = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (unit_done) begin
               base_in  = unit_product;
               exp_in   = {1'b0, exp_ff[FIELD_WIDTH-1:1]};
               state_in = ST_PICK;
            end
         end
         ST_RESP: begin
            if (rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      exp_ff  <= exp_in;
      mod_ff  <= mod_in;
      base_ff <= base_in;
      acc_ff  <= acc_in;
   end

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = (state_ff == ST_RESP);
   assign rsp_chan.power_result = RESULT_WIDTH'(acc_ff);

endmodule

/* tb/sv/modular_exponentiation_test.sv */
// Self-checking testbench for modular_exponentiation: directed corner cases, then random
// requests with random gaps and output stalls, checked against a square-and-multiply predictor.
// Depends on mexp_pkg, mexp_req_if, mexp_rsp_if and the modular_exponentiation RTL.
`timescale 1ns / 100ps

module modular_exponentiation_test;
   import mexp_pkg::*;

   localparam int CLOCK_PERIOD = 10;
   localparam int RESET_CYCLES = 8;
   localparam int END_SETTLE   = 7000;
   localparam int CYCLE_LIMIT  = 4_000_000;
   localparam int HOLD_CYCLES  = 3000;

   typedef logic [FIELD_WIDTH-1:0]   field_type;
   typedef logic [MODULUS_WIDTH-1:0] modulus_type;
   typedef logic [RESULT_WIDTH-1:0]  power_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mexp_req_if req_chan();
   mexp_rsp_if rsp_chan();

   modular_exponentiation DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   power_type   expected_powers[$];
   power_type   wanted_power;
   int unsigned cycle_count     = 0;
   int unsigned requests_sent   = 0;
   int unsigned results_checked = 0;
   int unsigned mismatch_count  = 0;
   int          hold_off        = 0;
   int          stall_left      = 0;
   bit          idle_enable     = 1'b1;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   function automatic power_type modular_power(field_type base_in, field_type exp_in,
                                               modulus_type mod_in);
      logic [63:0] acc;
      logic [63:0] square;
      logic [63:0] mod_wide;
      field_type   bits;
      if (exp_in == '0) return power_type'(1);
      if (mod_in == '0) return '0;
      mod_wide = 64'(mod_in);
      square   = 64'(base_in) % mod_wide;
      acc      = 64'd1;
      bits     = exp_in;
      while (bits != '0) begin
         if (bits[0]) acc = (acc * square) % mod_wide;
         square = (square * square) % mod_wide;
         bits   = bits >> 1;
      end
      return acc[RESULT_WIDTH-1:0];
   endfunction

   function automatic int pick_gap();
      int roll;
      if (!idle_enable) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic field_type random_field(int bits);
      field_type value;
      field_type mask;
      value = field_type'({$urandom, $urandom});
      mask  = (field_type'(1) << bits) - field_type'(1);
      return value & mask;
   endfunction

   function automatic field_type random_base();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 5) return random_field(FIELD_WIDTH);
      if (roll < 8) return random_field($urandom_range(1, 16));
      return random_field($urandom_range(17, 40));
   endfunction

   // keep most exponents short: latency grows with the exponent's bit length
   function automatic field_type random_exponent();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return random_field($urandom_range(1, 16));
      if (roll < 90) return random_field($urandom_range(17, 32));
      return random_field(FIELD_WIDTH);
   endfunction

   function automatic modulus_type random_modulus();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return modulus_type'($urandom);
      if (roll < 80) return modulus_type'($urandom_range(1, 255));
      if (roll < 86) return modulus_type'($urandom_range(256, 65535));
      if (roll < 90) return '0;
      if (roll < 94) return modulus_type'(1);
      return '1;
   endfunction

   // hold valid high after acceptance; drop it only when the stream pauses
   task automatic send_request(field_type base_in, field_type exp_in, modulus_type mod_in);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.base_value <= base_in;
      req_chan.exponent   <= exp_in;
      req_chan.modulus    <= mod_in;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      expected_powers.push_back(modular_power(base_in, exp_in, mod_in));
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic wait_for_drain(int extra);
      req_chan.valid <= 1'b0;
      while (expected_powers.size() != 0) @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   task automatic test_corner_cases();
      idle_enable = 1'b1;
      send_request(field_type'(12345), '0, modulus_type'(1));
      send_request(field_type'(12345), '0, '0);
      send_request('1, '0, '1);
      send_request(field_type'(7), field_type'(1), '0);
      send_request('1, '1, '0);
      send_request(field_type'(7), field_type'(5), modulus_type'(1));
      send_request('0, '1, '1);
      send_request('1, '1, '1);
      send_request('1, field_type'(1), '1);
      send_request(field_type'(2), field_type'(10), modulus_type'(1000));
      send_request(field_type'(64'hFFFF_FFFE), field_type'(2), '1);
      send_request(field_type'(3), field_type'(64'hFFFF_FFFA), modulus_type'(32'hFFFF_FFFB));
      send_request(field_type'(3), field_type'(1) << (FIELD_WIDTH - 1),
                   modulus_type'(1000003));
      send_request(field_type'(1000003), field_type'(9), modulus_type'(1000003));
      send_request(field_type'(64'h5555_5555_5555_5555), '1, modulus_type'(2));
      send_request(field_type'(3), field_type'(64'h5555_5555), modulus_type'(32'h8000_0000));
      send_request(field_type'(64'h2AAA_AAAA_AAAA_AAAA), field_type'(64'h2AAA_AAAA_AAAA_AAAA),
                   modulus_type'(32'hAAAA_AAAB));
      wait_for_drain(8);
   endtask

   task automatic test_steady_stream();
      idle_enable = 1'b0;
      repeat (40) send_request(random_base(), random_exponent(), random_modulus());
      wait_for_drain(8);
   endtask

   task automatic test_random_gaps();
      idle_enable = 1'b1;
      repeat (75) send_request(random_base(), random_exponent(), random_modulus());
      wait_for_drain(8);
   endtask

   task automatic test_output_hold_off();
      idle_enable = 1'b1;
      @(posedge clock);
      hold_off = HOLD_CYCLES;
      @(negedge clock);
      repeat (12) begin
         send_request(random_base(), random_field($urandom_range(1, 8)), random_modulus());
      end
      wait_for_drain(8);
   endtask

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (hold_off > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_off--;
         end else if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (expected_powers.size() == 0) begin
            $error("power_result: expected none, actual %0h", rsp_chan.power_result);
            mismatch_count++;
         end else begin
            wanted_power = expected_powers.pop_front();
            results_checked++;
            if (rsp_chan.power_result !== wanted_power) begin
               $error("power_result: expected %0h, actual %0h", wanted_power,
                      rsp_chan.power_result);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
   end

   initial begin
      req_chan.valid      = 1'b0;
      req_chan.base_value = '0;
      req_chan.exponent   = '0;
      req_chan.modulus    = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      test_corner_cases();
      test_steady_stream();
      test_random_gaps();
      test_output_hold_off();
      wait_for_drain(END_SETTLE);
      if (expected_powers.size() != 0) begin
         $error("power_result: %0d results never arrived", expected_powers.size());
         mismatch_count++;
      end
      $display("covered corner cases, steady and gapped random streams, long output hold-off");
      $display("%0d requests, %0d results checked, %0d mismatches, %0d cycles",
               requests_sent, results_checked, mismatch_count, cycle_count);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* files.f */
sv/mexp_pkg.sv
sv/mexp_req_if.sv
sv/mexp_rsp_if.sv
sv/mexp_mulmod.sv
sv/modular_exponentiation.sv
tb/sv/modular_exponentiation_test.sv
